// ----- rtl/prt_pkg.sv -----
// Shared types and constants for the periodic release timer.
`default_nettype none

package prt_pkg;

	// Time and field widths.
	localparam int TIME_W   = 48;
	localparam int PERIOD_W = 16;
	localparam int COUNT_W  = 3;
	localparam int SLOT_W   = 2;
	localparam int REG_IDX_W = 3;

	// Number of slots that own a period register.
	localparam int NUM_PERIOD_REGS = 4;

	// Wake-up cap added to the current time on every tick.
	localparam logic [TIME_W-1:0] WAKE_CAP = 48'd100;

	// Request kinds.
	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_TICK  = 2'd1,
		KIND_STOP  = 2'd2
	} kind_t;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_PERIOD0    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD1    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD2    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD3    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TASK_COUNT = 3'd4;

	// Outcome of evaluating one slot on a tick.
	typedef struct packed {
		logic              fire;
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] wake;
	} slot_upd_t;

endpackage

`default_nettype wire

// ----- rtl/periodic_release_timer_core.sv -----
// Top level of the periodic release timer: configuration, sequencer and deadline memory.
//
// Usage. Requests enter on the input channel (in_valid, in_stall, kind, now_ms) and
// results leave on the output channel (out_valid, out_stall, fired, task_index,
// next_wakeup_ms, running, last). Slot periods and the slot count are written on
// the configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_wdata); the user
// must write them only while idle; the block does not enforce it. A start request
// on a stopped block writes every slot deadline into the deadline RAM, one slot a
// cycle, and then gives its single result. A start while running, a stop or an
// unknown kind gives its result. A tick reads, updates and writes back one
// enabled slot a cycle through the registered RAM read while the output is free,
// giving a release result for each due slot, then the summary. One request is in
// work at a time; in_stall is high from the cycle after acceptance until the
// summary result is registered, and the next request is taken while that result still
// waits at the output. When out_stall holds a result, a due slot waits in the
// update stage and no new read is issued until the output register frees.
// Reset clears the configuration, the running flag and all control state; the
// RAM needs no clearing since a tick only reads slots that a start has written.
`default_nettype none

module periodic_release_timer_core #(
	parameter int TASKS = 4
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Request channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [1:0]                         kind,
	input  wire logic [prt_pkg::TIME_W-1:0]         now_ms,
	// Result channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic                                    fired,
	output logic [prt_pkg::SLOT_W-1:0]              task_index,
	output logic [prt_pkg::TIME_W-1:0]              next_wakeup_ms,
	output logic                                    running,
	output logic                                    last,
	// Configuration channel
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [prt_pkg::REG_IDX_W-1:0]      cfg_index,
	input  wire logic [prt_pkg::PERIOD_W-1:0]       cfg_wdata
);

	import prt_pkg::*;

	localparam int ADDR_W = (TASKS > 1) ? $clog2(TASKS) : 1;
	localparam int CNT_W  = ($clog2(TASKS + 1) > COUNT_W) ? $clog2(TASKS + 1) : COUNT_W;
	localparam int LIM    = (TASKS < NUM_PERIOD_REGS) ? TASKS : NUM_PERIOD_REGS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_WALK,
		S_FINAL
	} state_t;

	// Configuration registers.
	logic [PERIOD_W-1:0] period_q [NUM_PERIOD_REGS];
	logic [COUNT_W-1:0]  task_count_q;

	// Sequencer state.
	state_t              state_q;
	logic                active_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [COUNT_W-1:0]  n_q;
	logic [TIME_W-1:0]   now_q;
	logic [TIME_W-1:0]   wake_q;

	// Update stage: slot whose deadline arrives from the RAM this cycle.
	logic                dv_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [PERIOD_W-1:0] period_s1;

	// Output register.
	logic                out_valid_q;
	logic                out_fired_q;
	logic [SLOT_W-1:0]   out_index_q;
	logic [TIME_W-1:0]   out_wake_q;
	logic                out_running_q;
	logic                out_last_q;

	// Datapath nets.
	logic                in_acc;
	logic                out_free;
	logic                out_load;
	logic [PERIOD_W-1:0] cnt_period;
	logic [COUNT_W-1:0]  enabled_n;
	logic [TIME_W-1:0]   rd_deadline;
	slot_upd_t           upd;
	logic                blocked;
	logic                proceed;
	logic                issue;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [TIME_W-1:0]   ram_wdata;
	logic                ram_re;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PERIOD_REGS; i++) begin
				period_q[i] <= '0;
			end
			task_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PERIOD0:    period_q[0] <= cfg_wdata;
				REG_PERIOD1:    period_q[1] <= cfg_wdata;
				REG_PERIOD2:    period_q[2] <= cfg_wdata;
				REG_PERIOD3:    period_q[3] <= cfg_wdata;
				REG_TASK_COUNT: task_count_q <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Period of the slot under the counter; slots without a register have none.
	assign cnt_period = (cnt_q < CNT_W'(NUM_PERIOD_REGS)) ? period_q[cnt_q[1:0]] : '0;

	// Enabled slot count saturates at the smaller of the register count and TASKS.
	assign enabled_n = (task_count_q > COUNT_W'(LIM)) ? COUNT_W'(LIM) : task_count_q;

	// Slot evaluation for the deadline returned by the RAM.
	prt_slot_upd u_slot_upd (
		.deadline (rd_deadline),
		.period   (period_s1),
		.now      (now_q),
		.wake     (wake_q),
		.upd      (upd)
	);

	// Walk control: a due slot waits while the output register is occupied.
	assign blocked = dv_s1 && upd.fire && !out_free;
	assign proceed = !blocked;
	assign issue   = (state_q == S_WALK) && proceed && (cnt_q < CNT_W'(n_q));

	// A release or a summary result enters the output register this cycle.
	assign out_load = ((state_q == S_WALK) && proceed && dv_s1 && upd.fire) ||
		((state_q == S_FINAL) && out_free);

	// RAM access: sweep writes on start, write-back of due slots on tick.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q[ADDR_W-1:0];
		ram_wdata = now_q + {{(TIME_W-PERIOD_W){1'b0}}, cnt_period};
		case (state_q)
			S_SWEEP: begin
				ram_we = 1'b1;
			end
			S_WALK: begin
				ram_we    = dv_s1 && upd.fire && proceed;
				ram_waddr = ADDR_W'(slot_s1);
				ram_wdata = upd.deadline;
			end
			default: ;
		endcase
	end

	assign ram_re = issue;

	prt_ram #(
		.WIDTH (TIME_W),
		.DEPTH (TASKS)
	) u_deadline_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cnt_q[ADDR_W-1:0]),
		.rdata (rd_deadline)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			active_q      <= 1'b0;
			cnt_q         <= '0;
			n_q           <= '0;
			now_q         <= '0;
			wake_q        <= '0;
			dv_s1         <= 1'b0;
			slot_s1       <= '0;
			period_s1     <= '0;
			out_valid_q   <= 1'b0;
			out_fired_q   <= 1'b0;
			out_index_q   <= '0;
			out_wake_q    <= '0;
			out_running_q <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			// A new result fills the output register; a taken result frees it.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						now_q <= now_ms;
						cnt_q <= '0;
						dv_s1 <= 1'b0;
						n_q   <= active_q ? enabled_n : '0;
						if (kind == KIND_TICK) begin
							wake_q <= now_ms + WAKE_CAP;
						end else begin
							wake_q <= '0;
						end
						case (kind)
							KIND_START: begin
								if (!active_q) begin
									active_q <= 1'b1;
									state_q  <= S_SWEEP;
								end else begin
									state_q <= S_FINAL;
								end
							end
							KIND_TICK: begin
								state_q <= S_WALK;
							end
							KIND_STOP: begin
								active_q <= 1'b0;
								state_q  <= S_FINAL;
							end
							default: begin
								state_q <= S_FINAL;
							end
						endcase
					end
				end
				S_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(TASKS - 1)) begin
						state_q <= S_FINAL;
					end
				end
				S_WALK: begin
					if (proceed) begin
						// Retire the slot in the update stage.
						if (dv_s1) begin
							wake_q <= upd.wake;
							if (upd.fire) begin
								out_fired_q   <= 1'b1;
								out_index_q   <= slot_s1;
								out_wake_q    <= '0;
								out_running_q <= active_q;
								out_last_q    <= 1'b0;
							end
						end
						// Read the next enabled slot, or finish the walk.
						dv_s1 <= issue;
						if (issue) begin
							slot_s1   <= cnt_q[SLOT_W-1:0];
							period_s1 <= cnt_period;
							cnt_q     <= cnt_q + 1'b1;
						end else begin
							state_q <= S_FINAL;
						end
					end
				end
				S_FINAL: begin
					if (out_free) begin
						out_fired_q   <= 1'b0;
						out_index_q   <= '0;
						out_wake_q    <= wake_q;
						out_running_q <= active_q;
						out_last_q    <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign fired          = out_fired_q;
	assign task_index     = out_index_q;
	assign next_wakeup_ms = out_wake_q;
	assign running        = out_running_q;
	assign last           = out_last_q;

	// The deadline RAM is only written while a request is in work.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q != S_IDLE))
		else $error("deadline RAM written while idle");

	// An accepted request always keeps the input stalled in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("input not stalled after acceptance");

	// The update stage only holds a slot during a walk.
	a_stage_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		dv_s1 |-> (state_q == S_WALK))
		else $error("update stage occupied outside a walk");

	// A release is only reported while running, and never as the final result.
	a_fired_running: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_fired_q) |-> (out_running_q && !out_last_q))
		else $error("release result while stopped or marked final");

endmodule

`default_nettype wire

// ----- rtl/prt_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module prt_ram #(
	parameter int WIDTH  = 48,
	parameter int DEPTH  = 4,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/prt_slot_upd.sv -----
// Deadline evaluation for one slot on a tick: release test, advance and wake-up minimum.
`default_nettype none

module prt_slot_upd (
	input  wire logic [prt_pkg::TIME_W-1:0]   deadline,
	input  wire logic [prt_pkg::PERIOD_W-1:0] period,
	input  wire logic [prt_pkg::TIME_W-1:0]   now,
	input  wire logic [prt_pkg::TIME_W-1:0]   wake,
	output prt_pkg::slot_upd_t                upd
);

	import prt_pkg::*;

	logic [TIME_W-1:0] advanced;
	logic [TIME_W-1:0] from_now;
	logic [TIME_W-1:0] next_dl;
	logic              fire;

	// A slot is due once its deadline is at or before now.
	assign fire     = (now >= deadline);
	assign advanced = deadline + {{(TIME_W-PERIOD_W){1'b0}}, period};
	assign from_now = now + {{(TIME_W-PERIOD_W){1'b0}}, period};

	// Skip missed periods: restart from now when the advance is still due.
	always_comb begin
		if (!fire) begin
			next_dl = deadline;
		end else if (advanced <= now) begin
			next_dl = from_now;
		end else begin
			next_dl = advanced;
		end
	end

	assign upd.fire     = fire;
	assign upd.deadline = next_dl;
	assign upd.wake     = (next_dl < wake) ? next_dl : wake;

endmodule

`default_nettype wire
